// File: rtl/core/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants for the free-fall / impact fall detector.
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam int FIELD_W  = 16;
	localparam int LEVEL_W  = 32;
	localparam int SAMPLE_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_FREEFALL_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_LEVEL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF        = 2'd3;

	localparam logic [LEVEL_W-1:0]  FREEFALL_LEVEL_RST = 32'd1570009;
	localparam logic [LEVEL_W-1:0]  IMPACT_LEVEL_RST   = 32'd69789316;
	localparam logic [SAMPLE_W-1:0] WINDOW_RST         = 16'd50;
	localparam logic [SAMPLE_W-1:0] HOLDOFF_RST        = 16'd150;

	typedef struct packed {
		logic [LEVEL_W-1:0]  freefall_level_sq;
		logic [LEVEL_W-1:0]  impact_level_sq;
		logic [SAMPLE_W-1:0] window_samples;
		logic [SAMPLE_W-1:0] holdoff_samples;
	} cfg_t;

	typedef struct packed {
		logic fall_detected;
		logic freefall_armed;
		logic in_holdoff;
	} det_flags_t;

endpackage

// File: rtl/core/ffd_mag.sv
// ----------------------------------------------------------------------------
// ffd_mag
// Squared magnitude of a three-axis sample: x*x + y*y + z*z, exact.
// ----------------------------------------------------------------------------
module ffd_mag import ffd_pkg::*; #(
	parameter int AXIS_BITS = 16
) (
	input  logic signed [FIELD_W-1:0] accel_x,
	input  logic signed [FIELD_W-1:0] accel_y,
	input  logic signed [FIELD_W-1:0] accel_z,
	output logic        [LEVEL_W-1:0] mag_sq
);

	function automatic logic [LEVEL_W-1:0] axis_sq(input logic [FIELD_W-1:0] raw);
		logic [AXIS_BITS-1:0]   v;
		logic [AXIS_BITS-1:0]   m;
		logic [2*AXIS_BITS-1:0] sq;
		v  = raw[AXIS_BITS-1:0];
		m  = v[AXIS_BITS-1] ? (~v + 1'b1) : v;
		sq = m * m;
		return LEVEL_W'(sq);
	endfunction

	assign mag_sq = axis_sq(accel_x) + axis_sq(accel_y) + axis_sq(accel_z);

endmodule

// File: rtl/core/ffd_ctrl.sv
// ----------------------------------------------------------------------------
// ffd_ctrl
// Arm / window / hold-off state and the per-sample fall decision.
// ----------------------------------------------------------------------------
module ffd_ctrl import ffd_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [LEVEL_W-1:0] mag_sq,
	input  cfg_t               cfg,
	output det_flags_t         flags
);

	localparam int CMP_W = (COUNT_BITS > SAMPLE_W) ? COUNT_BITS : SAMPLE_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                  armed_q, armed_d;
	logic [COUNT_BITS-1:0] since_q, since_d, since_inc;
	logic [COUNT_BITS-1:0] hold_q, hold_d, hold_load;
	logic [CMP_W-1:0]      hold_ext;
	logic                  in_window;

	assign since_inc = (since_q != CNT_MAX) ? since_q + 1'b1 : since_q;
	assign in_window = CMP_W'(since_inc) <= CMP_W'(cfg.window_samples);
	assign hold_ext  = CMP_W'(cfg.holdoff_samples);
	assign hold_load = (hold_ext > CMP_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(hold_ext);

	always_comb begin
		armed_d = armed_q;
		since_d = since_q;
		hold_d  = hold_q;
		flags.fall_detected = 1'b0;
		flags.in_holdoff    = 1'b0;
		if (hold_q != '0) begin
			hold_d = hold_q - 1'b1;
			flags.in_holdoff = 1'b1;
		end else if (!armed_q) begin
			if (mag_sq < cfg.freefall_level_sq) begin
				armed_d = 1'b1;
				since_d = '0;
			end
		end else begin
			since_d = since_inc;
			if (in_window) begin
				if (mag_sq > cfg.impact_level_sq) begin
					flags.fall_detected = 1'b1;
					armed_d = 1'b0;
					hold_d  = hold_load;
				end
			end else begin
				armed_d = 1'b0;
			end
		end
		flags.freefall_armed = armed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			since_q <= '0;
			hold_q  <= '0;
		end else if (step) begin
			armed_q <= armed_d;
			since_q <= since_d;
			hold_q  <= hold_d;
		end
	end

endmodule

// File: rtl/core/freefall_impact_fall_detector_top.sv
// ----------------------------------------------------------------------------
// freefall_impact_fall_detector_top
// Pipeline: input registers (s1), combinational magnitude/decision, output (s2).
// Throughput: 1 item per cycle while the s2 output is empty or m_tready is high.
// Reset: arst_n clears detector state and valids and loads default thresholds.
// ----------------------------------------------------------------------------
module freefall_impact_fall_detector_top import ffd_pkg::*; #(
	parameter int AXIS_BITS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // fall_detected, severity_sq,
	                                         // freefall_armed, in_holdoff, pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                      cfg_q;
	logic                      vld_s1;
	logic signed [FIELD_W-1:0] x_s1, y_s1, z_s1;
	logic                      out_free, adv;
	logic [LEVEL_W-1:0]        mag_sq;
	det_flags_t                flags;
	logic                      vld_s2;
	logic [OUT_DATA_W-1:0]     data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freefall_level_sq <= FREEFALL_LEVEL_RST;
			cfg_q.impact_level_sq   <= IMPACT_LEVEL_RST;
			cfg_q.window_samples    <= WINDOW_RST;
			cfg_q.holdoff_samples   <= HOLDOFF_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FREEFALL_LEVEL: cfg_q.freefall_level_sq <= cfg_data;
				CFG_IMPACT_LEVEL:   cfg_q.impact_level_sq   <= cfg_data;
				CFG_WINDOW:         cfg_q.window_samples    <= cfg_data[SAMPLE_W-1:0];
				CFG_HOLDOFF:        cfg_q.holdoff_samples   <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !vld_s2 || m_tready;
	assign adv      = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1 <= s_tdata[FIELD_W-1:0];
			y_s1 <= s_tdata[2*FIELD_W-1:FIELD_W];
			z_s1 <= s_tdata[3*FIELD_W-1:2*FIELD_W];
		end
	end

	ffd_mag #(.AXIS_BITS(AXIS_BITS)) u_mag (
		.accel_x (x_s1),
		.accel_y (y_s1),
		.accel_z (z_s1),
		.mag_sq  (mag_sq)
	);

	ffd_ctrl #(.COUNT_BITS(COUNT_BITS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.mag_sq (mag_sq),
		.cfg    (cfg_q),
		.flags  (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {5'b0, flags.in_holdoff, flags.freefall_armed, mag_sq,
				flags.fall_detected};
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = data_s2;

endmodule

// File: rtl/core/ffd_chk.sv
// ----------------------------------------------------------------------------
// ffd_chk
// Port-level checks for the fall detector, bound to the top level.
// ----------------------------------------------------------------------------
module ffd_chk import ffd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_rst_no_valid: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	a_fall_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[33])
		else $error("fall reported while still armed");

	a_holdoff_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> !m_tdata[0] && !m_tdata[33])
		else $error("ignored item shows fall or armed");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind freefall_impact_fall_detector_top ffd_chk u_ffd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/tb_freefall_impact_fall_detector_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_freefall_impact_fall_detector_top
// Self-checking bench for the free-fall / impact fall detector. A directed
// table covers the reset levels, the level and window boundaries, sign
// handling and hold-off. Randomized phases follow, each with its own register
// setting and idle pattern. Free-fall, quiet and impact samples are mixed with
// noise. Every result item is checked: typed table rows against their listed
// values, all other items against an in-bench detector model.
module tb_freefall_impact_fall_detector_top;
	import ffd_pkg::*;

	typedef struct {
		logic        fall;
		logic [31:0] sev;
		logic        armed;
		logic        hold;
	} det_result_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [16:0]        reps;
		logic               typed;
		logic               fall;
		logic [31:0]        sev;
		logic               armed;
		logic               hold;
	} stim_row_t;

	typedef enum {SMP_FREEFALL, SMP_QUIET, SMP_IMPACT, SMP_NOISE} sample_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // accel_x, accel_y, accel_z
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // fall_detected, severity_sq,
	                                       // freefall_armed, in_holdoff, pad
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// detector model state and registers
	logic [31:0] ff_level = FREEFALL_LEVEL_RST;
	logic [31:0] impact_level = IMPACT_LEVEL_RST;
	logic [15:0] window_len = WINDOW_RST;
	logic [15:0] holdoff_len = HOLDOFF_RST;
	logic        armed = 1'b0;
	logic [15:0] since_ff = '0;
	logic [15:0] holdoff_left = '0;
	int          ff_span;

	det_result_t pending_results[$];
	det_result_t want;
	int          errors = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          samples_sent = 0;

	stim_row_t directed_rows [0:14] = '{
		'{16'sd0, 16'sd0, 16'sd0, 17'd1, 1'b1, 1'b0, 32'd0, 1'b1, 1'b0},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 17'd1, 1'b1, 1'b1, 32'd3221225472,
			1'b0, 1'b0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 17'd1, 1'b1, 1'b0, 32'd3221028867,
			1'b0, 1'b1},
		'{16'sd4096, 16'sd0, 16'sd0, 17'd149, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
		'{16'sd4096, 16'sd0, 16'sd0, 17'd1, 1'b1, 1'b0, 32'd16777216, 1'b0, 1'b0},
		'{16'sd1253, 16'sd0, 16'sd0, 17'd1, 1'b1, 1'b0, 32'd1570009, 1'b0, 1'b0},
		'{16'sd0, -16'sd1252, 16'sd0, 17'd1, 1'b1, 1'b0, 32'd1567504, 1'b1, 1'b0},
		'{16'sd0, 16'sd0, 16'sd8354, 17'd1, 1'b1, 1'b0, 32'd69789316, 1'b1, 1'b0},
		'{16'sd0, 16'sd4096, 16'sd0, 17'd49, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
		'{16'sd0, 16'sd0, -16'sd4096, 17'd1, 1'b1, 1'b0, 32'd16777216, 1'b0, 1'b0},
		'{-16'sd1, 16'sd1, -16'sd1, 17'd1, 1'b1, 1'b0, 32'd3, 1'b1, 1'b0},
		'{16'sd0, 16'sd4096, 16'sd0, 17'd48, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
		'{-16'sd8355, 16'sd0, 16'sd0, 17'd1, 1'b1, 1'b1, 32'd69806025, 1'b0, 1'b0},
		'{16'sd4096, 16'sd0, 16'sd0, 17'd150, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0},
		'{-16'sd32768, 16'sd0, 16'sd0, 17'd1, 1'b1, 1'b0, 32'd1073741824, 1'b0, 1'b0}
	};

	freefall_impact_fall_detector_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] magnitude_sq(logic [47:0] d);
		int x;
		int y;
		int z;
		x = int'($signed(d[15:0]));
		y = int'($signed(d[31:16]));
		z = int'($signed(d[47:32]));
		return 32'(x * x) + 32'(y * y) + 32'(z * z);
	endfunction

	function automatic det_result_t step_detector(logic [47:0] d);
		det_result_t r;
		logic [31:0] mag;
		mag = magnitude_sq(d);
		r.fall = 1'b0;
		r.hold = 1'b0;
		if (holdoff_left != 0) begin
			holdoff_left--;
			r.hold = 1'b1;
		end else if (!armed) begin
			if (mag < ff_level) begin
				armed = 1'b1;
				since_ff = '0;
			end
		end else begin
			if (since_ff != 16'hFFFF)
				since_ff++;
			if (since_ff <= window_len) begin
				if (mag > impact_level) begin
					r.fall = 1'b1;
					armed = 1'b0;
					holdoff_left = holdoff_len;
				end
			end else begin
				armed = 1'b0;
			end
		end
		r.sev = mag;
		r.armed = armed;
		return r;
	endfunction

	// largest per-axis value a with 3*a*a below the level, -1 if none
	function automatic int axis_span(logic [31:0] level);
		longint lo;
		longint hi;
		longint mid;
		if (level == 0)
			return -1;
		lo = 0;
		hi = 32767;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (3 * mid * mid < longint'(level))
				lo = mid;
			else
				hi = mid - 1;
		end
		return int'(lo);
	endfunction

	function automatic int spread(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic logic [47:0] pack_axes(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic [47:0] pick_sample(sample_kind_t kind);
		logic [47:0] d;
		logic [31:0] m;
		d = 48'({$urandom, $urandom});
		if (kind == SMP_NOISE)
			return d;
		for (int i = 0; i < 32; i++) begin
			case (kind)
				SMP_FREEFALL: begin
					if (ff_span < 0)
						d = '0;
					else
						d = pack_axes(spread(ff_span), spread(ff_span), spread(ff_span));
				end
				SMP_QUIET: d = pack_axes(spread(8191), spread(8191), spread(8191));
				default:   d = 48'({$urandom, $urandom});
			endcase
			m = magnitude_sq(d);
			if ((kind == SMP_FREEFALL && m < ff_level) ||
			    (kind == SMP_QUIET && m >= ff_level && m <= impact_level) ||
			    (kind == SMP_IMPACT && m > impact_level))
				return d;
		end
		return d;
	endfunction

	task automatic push_sample(logic [47:0] d, logic typed, det_result_t typed_res);
		det_result_t r;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = step_detector(d);
		pending_results.push_back(typed ? typed_res : r);
		samples_sent++;
	endtask

	task automatic push_kind(sample_kind_t kind);
		det_result_t unused;
		unused = '{1'b0, 32'd0, 1'b0, 1'b0};
		push_sample(pick_sample(kind), 1'b0, unused);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [31:0] ff, logic [31:0] imp, logic [15:0] win,
	                         logic [15:0] hold);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_FREEFALL_LEVEL;
		cfg_data <= ff;
		@(posedge clk);
		cfg_addr <= CFG_IMPACT_LEVEL;
		cfg_data <= imp;
		@(posedge clk);
		cfg_addr <= CFG_WINDOW;
		cfg_data <= {16'd0, win};
		@(posedge clk);
		cfg_addr <= CFG_HOLDOFF;
		cfg_data <= {16'd0, hold};
		@(posedge clk);
		cfg_we <= 1'b0;
		ff_level = ff;
		impact_level = imp;
		window_len = win;
		holdoff_len = hold;
		ff_span = axis_span(ff);
	endtask

	task automatic run_phase(logic [31:0] ff, logic [31:0] imp, logic [15:0] win,
	                         logic [15:0] hold, int idle_pct, int stall_pct, int n);
		int start;
		int pick;
		int lim;
		drain();
		configure(ff, imp, win, hold);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		start = samples_sent;
		lim = (win > 18) ? 20 : int'(win) + 2;
		while (samples_sent - start < n) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				push_kind(SMP_FREEFALL);
				repeat ($urandom_range(lim)) push_kind(SMP_QUIET);
				push_kind(SMP_IMPACT);
				repeat ($urandom_range(3)) push_kind(SMP_QUIET);
			end else if (pick < 90) begin
				push_kind(SMP_NOISE);
			end else begin
				push_kind(SMP_FREEFALL);
				repeat ($urandom_range(30)) push_kind(SMP_QUIET);
			end
		end
	endtask

	// result side: random stall and compare against the oldest expectation
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result item with nothing pending: %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.fall || m_tdata[32:1] !== want.sev ||
				    m_tdata[33] !== want.armed || m_tdata[34] !== want.hold) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %0b/%0d/%0b/%0b got %0b/%0d/%0b/%0b",
						         want.fall, want.sev, want.armed, want.hold,
						         m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[34]);
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("tb_freefall_impact_fall_detector_top: errors");
		$finish;
	end

	initial begin
		det_result_t exp_row;
		ff_span = axis_span(ff_level);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels, boundaries, sign handling, hold-off length
		foreach (directed_rows[i]) begin
			exp_row = '{directed_rows[i].fall, directed_rows[i].sev,
			            directed_rows[i].armed, directed_rows[i].hold};
			repeat (directed_rows[i].reps)
				push_sample(pack_axes(directed_rows[i].x, directed_rows[i].y,
				                      directed_rows[i].z),
				            directed_rows[i].typed, exp_row);
		end

		run_phase(32'd1570009, 32'd69789316, 16'd50, 16'd7, 0, 0, 50);
		run_phase(32'd0, 32'd0, 16'd0, 16'd0, 72, 0, 50);
		run_phase(32'd3221225472, 32'd0, 16'd0, 16'd0, 0, 72, 50);
		run_phase(32'd20000000, 32'd3221225472, 16'd65535, 16'd65535, 21, 21, 50);
		run_phase(32'd4000000, 32'd100000000, 16'd3, 16'd0, 72, 0, 50);
		run_phase(32'd1570009, 32'd69789316, 16'd12, 16'd4, 0, 72, 50);
		run_phase($urandom_range(40000000), $urandom_range(2000000000, 20000000),
		          16'($urandom_range(20)), 16'($urandom_range(10)), 21, 21, 50);
		run_phase($urandom_range(10000000), $urandom_range(400000000, 30000000),
		          16'($urandom_range(40)), 16'($urandom_range(20)), 0, 0, 50);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_freefall_impact_fall_detector_top: clean");
		else
			$display("tb_freefall_impact_fall_detector_top: errors");
		$finish;
	end

endmodule
